// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files of the COO to ELLPACK builder.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// cons must hold in the same cycle as ante
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/c2e_pkg.sv =====
// Shared codes and types of the COO to ELLPACK builder.
// No dependencies; imported by c2e_pad_len and coo_to_ellpack_builder_unit.
`timescale 1ns / 1ps

package c2e_pkg;

    // command modes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_ROW  = 2'd1;
    localparam logic [1:0] STAT_ROW_FULL = 2'd2;
    localparam logic [1:0] STAT_BAD_SLOT = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_MODULO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_VALUE   = 2'd2;

    localparam logic [10:0] ACTIVE_ROWS_RESET = 11'd1024;
    localparam logic [6:0]  PAD_MODULO_RESET  = 7'd1;

    // control from the sequencer to the padded length unit
    typedef struct packed {
        logic clear;      // store cleared, longest row back to zero
        logic bump;       // longest row grows by one this cycle
        logic recompute;  // pad modulo rewritten
    } t_pad_ctrl;

endpackage

// ===== src/c2e_pad_len.sv =====
// Padded row length tracker: smallest multiple of the pad modulo above the longest row.
// Depends on c2e_pkg (t_pad_ctrl) and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module c2e_pad_len
    import c2e_pkg::*;
#(
    parameter int ROW_SLOTS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_pad_ctrl                          i_ctrl,
    input  logic [6:0]                         i_modulo,
    input  logic [$clog2(ROW_SLOTS+1)-1:0]     i_max_count,
    output logic [$clog2(ROW_SLOTS+128)-1:0]   o_len,
    output logic                               o_busy
);

    localparam int LW = $clog2(ROW_SLOTS + 128);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_LOAD = 2'd1;
    localparam logic [1:0] P_ITER = 2'd2;

    logic [1:0]    r_state;
    logic [LW-1:0] r_len;
    logic [6:0]    mod_eff;
    logic [LW-1:0] mod_w;
    logic [LW-1:0] max_w;

    assign mod_eff = (i_modulo == 7'd0) ? 7'd1 : i_modulo;
    assign mod_w   = LW'(mod_eff);
    assign max_w   = LW'(i_max_count);

    // a rewrite of the modulo walks multiples up from the modulo, one add a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
            r_len   <= LW'(1);
        end else if (i_ctrl.recompute) begin
            r_state <= P_LOAD;
        end else begin
            case (r_state)
                P_IDLE: begin
                    if (i_ctrl.clear) begin
                        r_len <= mod_w;
                    end else if (i_ctrl.bump && (max_w + LW'(1) == r_len)) begin
                        r_len <= r_len + mod_w;
                    end
                end
                P_LOAD: begin
                    r_len   <= mod_w;
                    r_state <= P_ITER;
                end
                P_ITER: begin
                    if (r_len <= max_w) begin
                        r_len <= r_len + mod_w;
                    end else begin
                        r_state <= P_IDLE;
                    end
                end
                default: begin
                    r_state <= P_IDLE;
                end
            endcase
        end
    end

    assign o_len  = r_len;
    assign o_busy = (r_state != P_IDLE) || i_ctrl.recompute;

    `ASSERT_IMPLY(a_len_nonzero, i_clk, i_rst_n, 1'b1, r_len != '0)
    `ASSERT_IMPLY(a_len_above_max, i_clk, i_rst_n,
        (r_state == P_IDLE) && !i_ctrl.recompute, r_len > max_w)
    `ASSERT_NEXT(a_len_holds, i_clk, i_rst_n,
        (r_state == P_IDLE) && !i_ctrl.recompute && !i_ctrl.bump && !i_ctrl.clear,
        $stable(r_len))

endmodule

// ===== src/coo_to_ellpack_builder_unit.sv =====
// Top level of the COO to ELLPACK builder: row count memory, entry memory, sequencer.
// Depends on c2e_pkg, c2e_pad_len and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel     | Ports                                              | Transaction
// ------------+----------------------------------------------------+---------------------------
// command     | start, busy, i_mode, i_entry_row, i_entry_column,  | start high while busy low
//             | i_entry_value, i_read_slot                         |
// result      | o_strobe, o_out_column, o_out_value, o_is_pad,     | o_strobe high, one cycle
//             | o_status, o_longest_row, o_ell_width               |
// config      | i_cfg_we, i_cfg_index, i_cfg_data                  | i_cfg_we high
//
// Insert: an empty row or an error goes from COUNT to FINISH; otherwise SHIFT moves k entries,
//   k = stored entries of the row with a larger column (0..ROW_SLOTS-1); the entry memory
//   moves one entry per cycle (read, then write back one slot up).
// Read: padding or an error goes from COUNT to FINISH; a stored slot passes through FETCH.
// Clear: one row count zeroed per cycle through all MAX_ROWS rows, then FINISH.
// Reset: the same row count sweep runs over all MAX_ROWS rows; busy stays high until done.
// A pad_modulo write holds busy while the padded length is recomputed.
// The receiver cannot stall; a new command may be accepted in the strobe cycle.

module coo_to_ellpack_builder_unit
    import c2e_pkg::*;
#(
    parameter int MAX_ROWS  = 1024,
    parameter int ROW_SLOTS = 64,
    parameter int COL_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_mode,
    input  logic [9:0]            i_entry_row,
    input  logic [15:0]           i_entry_column,
    input  logic [31:0]           i_entry_value,
    input  logic [6:0]            i_read_slot,
    // result channel
    output logic                  o_strobe,
    output logic signed [16:0]    o_out_column,
    output logic [31:0]           o_out_value,
    output logic                  o_is_pad,
    output logic [1:0]            o_status,
    output logic [6:0]            o_longest_row,
    output logic [7:0]            o_ell_width,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(ROW_SLOTS + 1);
    localparam int LW = $clog2(ROW_SLOTS + 128);
    localparam int ED = MAX_ROWS * ROW_SLOTS;
    localparam int AW = (ED > 1) ? $clog2(ED) : 1;
    localparam int EW = COL_BITS + 32;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLEAR  = 3'd1;  // row count sweep
    localparam logic [2:0] S_COUNT  = 3'd2;  // row count read data valid
    localparam logic [2:0] S_SHIFT  = 3'd3;  // move larger columns up one slot
    localparam logic [2:0] S_PLACE  = 3'd4;  // new entry lands in slot 0
    localparam logic [2:0] S_FETCH  = 3'd5;  // entry read data valid
    localparam logic [2:0] S_FINISH = 3'd6;  // load result registers

    // memories: per-row entry count and the row-major entry store {column, value}
    logic [CW-1:0] r_count_mem [MAX_ROWS];
    logic [EW-1:0] r_entry_mem [ED];
    logic [CW-1:0] r_rc_q;
    logic [EW-1:0] r_es_q;

    // control state
    logic [2:0]    r_state;
    logic [RW-1:0] r_sweep;
    logic          r_clr_cmd;
    logic [CW-1:0] r_max;
    logic [10:0]   r_active_rows;
    logic [6:0]    r_pad_modulo;
    logic [31:0]   r_pad_value;
    logic          r_strobe;

    // captured command
    logic [1:0]          r_mode;
    logic [RW-1:0]       r_row;
    logic                r_row_ok;
    logic [COL_BITS-1:0] r_col;
    logic [31:0]         r_val;
    logic [6:0]          r_slot;
    logic [AW-1:0]       r_base;
    logic [CW-1:0]       r_pos;

    // result being built, then the output registers
    logic [16:0]   r_res_col;
    logic [31:0]   r_res_val;
    logic          r_res_pad;
    logic [1:0]    r_res_status;
    logic [16:0]   r_o_col;
    logic [31:0]   r_o_val;
    logic          r_o_pad;
    logic [1:0]    r_o_status;
    logic [6:0]    r_o_longest;
    logic [7:0]    r_o_padlen;

    logic          accept;
    logic          row_in_range;
    logic          row_has_room;
    logic          shift_more;
    logic          commit;
    logic          bump;
    logic [CW-1:0] n_count;
    logic [RW-1:0] rc_raddr;
    logic          rc_we;
    logic [RW-1:0] rc_waddr;
    logic [CW-1:0] rc_wdata;
    logic [AW-1:0] es_raddr;
    logic          es_we;
    logic [AW-1:0] es_waddr;
    logic [EW-1:0] es_wdata;
    t_pad_ctrl     pad_ctrl;
    logic [LW-1:0] pad_len;
    logic          pad_busy;

    assign busy   = (r_state != S_IDLE) || pad_busy;
    assign accept = start && !busy;

    assign row_in_range = (11'(i_entry_row) < r_active_rows) && (32'(i_entry_row) < MAX_ROWS);
    assign row_has_room = 32'(r_rc_q) < ROW_SLOTS;
    // the entry below the insertion point has a larger column: it moves up
    assign shift_more   = r_es_q[EW-1:32] > r_col;
    assign n_count      = r_rc_q + CW'(1);

    // the new entry is written and the row count bumped in exactly one cycle
    assign commit = ((r_state == S_COUNT) && (r_mode == MODE_INSERT) && r_row_ok
                        && row_has_room && (r_rc_q == '0))
                  || ((r_state == S_SHIFT) && !shift_more)
                  || (r_state == S_PLACE);
    assign bump   = commit && (n_count > r_max);

    assign pad_ctrl.clear     = accept && (i_mode == MODE_CLEAR);
    assign pad_ctrl.bump      = bump;
    assign pad_ctrl.recompute = i_cfg_we && (i_cfg_index == CFG_PAD_MODULO);

    c2e_pad_len #(
        .ROW_SLOTS (ROW_SLOTS)
    ) u_pad_len (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (pad_ctrl),
        .i_modulo    (r_pad_modulo),
        .i_max_count (r_max),
        .o_len       (pad_len),
        .o_busy      (pad_busy)
    );

    // row count port: read follows the command row, write is sweep or commit
    assign rc_raddr = (r_state == S_IDLE) ? RW'(i_entry_row) : r_row;
    assign rc_we    = (r_state == S_CLEAR) || commit;
    assign rc_waddr = (r_state == S_CLEAR) ? r_sweep : r_row;
    assign rc_wdata = (r_state == S_CLEAR) ? '0 : n_count;

    always_ff @(posedge i_clk) begin
        if (rc_we) begin
            r_count_mem[rc_waddr] <= rc_wdata;
        end
        r_rc_q <= r_count_mem[rc_raddr];
    end

    // entry store port: the read runs two slots below the write while shifting
    always_comb begin
        es_raddr = r_base;
        case (r_state)
            S_COUNT: begin
                if (r_mode == MODE_INSERT) begin
                    es_raddr = r_base + AW'(r_rc_q) - AW'(1);
                end else begin
                    es_raddr = r_base + AW'(r_slot);
                end
            end
            S_SHIFT: begin
                es_raddr = r_base + AW'(r_pos) - AW'(2);
            end
            default: begin
                es_raddr = r_base;
            end
        endcase
    end

    assign es_we    = commit || ((r_state == S_SHIFT) && shift_more);
    assign es_waddr = r_base + AW'(r_pos);
    assign es_wdata = commit ? {r_col, r_val} : r_es_q;

    always_ff @(posedge i_clk) begin
        if (es_we) begin
            r_entry_mem[es_waddr] <= es_wdata;
        end
        r_es_q <= r_entry_mem[es_raddr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_sweep       <= '0;
            r_clr_cmd     <= 1'b0;
            r_max         <= '0;
            r_active_rows <= ACTIVE_ROWS_RESET;
            r_pad_modulo  <= PAD_MODULO_RESET;
            r_pad_value   <= '0;
            r_strobe      <= 1'b0;
        end else begin
            // result registers load in the finish cycle; strobe is registered from it and shows with them
            r_strobe <= (r_state == S_FINISH);

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ACTIVE_ROWS: r_active_rows <= i_cfg_data[10:0];
                    CFG_PAD_MODULO:  r_pad_modulo  <= i_cfg_data[6:0];
                    CFG_PAD_VALUE:   r_pad_value   <= i_cfg_data[31:0];
                    default: begin
                    end
                endcase
            end

            if (bump) begin
                r_max <= n_count;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_mode       <= i_mode;
                        r_row        <= RW'(i_entry_row);
                        r_row_ok     <= row_in_range;
                        r_col        <= COL_BITS'(i_entry_column);
                        r_val        <= i_entry_value;
                        r_slot       <= i_read_slot;
                        r_base       <= AW'(RW'(i_entry_row)) * AW'(ROW_SLOTS);
                        r_pos        <= '0;
                        r_res_col    <= '0;
                        r_res_val    <= '0;
                        r_res_pad    <= 1'b0;
                        r_res_status <= STAT_OK;
                        if (i_mode == MODE_CLEAR) begin
                            r_sweep   <= '0;
                            r_clr_cmd <= 1'b1;
                            r_max     <= '0;
                            r_state   <= S_CLEAR;
                        end else begin
                            r_state <= S_COUNT;
                        end
                    end
                end
                S_CLEAR: begin
                    r_sweep <= r_sweep + RW'(1);
                    if (r_sweep == RW'(MAX_ROWS - 1)) begin
                        r_state   <= r_clr_cmd ? S_FINISH : S_IDLE;
                        r_clr_cmd <= 1'b0;
                    end
                end
                S_COUNT: begin
                    case (r_mode)
                        MODE_INSERT: begin
                            if (!r_row_ok) begin
                                r_res_status <= STAT_BAD_ROW;
                                r_state      <= S_FINISH;
                            end else if (!row_has_room) begin
                                r_res_status <= STAT_ROW_FULL;
                                r_state      <= S_FINISH;
                            end else if (r_rc_q != '0) begin
                                // slot count-1 is being read; compare it next cycle
                                r_pos   <= r_rc_q;
                                r_state <= S_SHIFT;
                            end else begin
                                r_state <= S_FINISH;
                            end
                        end
                        MODE_READ: begin
                            if (!r_row_ok) begin
                                r_res_status <= STAT_BAD_ROW;
                                r_state      <= S_FINISH;
                            end else if (32'(r_slot) < 32'(r_rc_q)) begin
                                r_state <= S_FETCH;
                            end else if (32'(r_slot) < 32'(pad_len)) begin
                                r_res_col <= '1;
                                r_res_val <= r_pad_value;
                                r_res_pad <= 1'b1;
                                r_state   <= S_FINISH;
                            end else begin
                                r_res_status <= STAT_BAD_SLOT;
                                r_state      <= S_FINISH;
                            end
                        end
                        default: begin
                            r_state <= S_FINISH;
                        end
                    endcase
                end
                S_SHIFT: begin
                    if (shift_more) begin
                        r_pos <= r_pos - CW'(1);
                        if (r_pos == CW'(1)) begin
                            r_state <= S_PLACE;
                        end
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_PLACE: begin
                    r_state <= S_FINISH;
                end
                S_FETCH: begin
                    r_res_col <= 17'(r_es_q[EW-1:32]);
                    r_res_val <= r_es_q[31:0];
                    r_state   <= S_FINISH;
                end
                S_FINISH: begin
                    // longest row and padded length have settled by now
                    r_o_col     <= r_res_col;
                    r_o_val     <= r_res_val;
                    r_o_pad     <= r_res_pad;
                    r_o_status  <= r_res_status;
                    r_o_longest <= 7'(r_max);
                    r_o_padlen  <= 8'(pad_len);
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe        = r_strobe;
    assign o_out_column    = $signed(r_o_col);
    assign o_out_value     = r_o_val;
    assign o_is_pad        = r_o_pad;
    assign o_status        = r_o_status;
    assign o_longest_row   = r_o_longest;
    assign o_ell_width     = r_o_padlen;

    `ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, r_strobe, !r_strobe)
    `ASSERT_IMPLY(a_max_bounded, i_clk, i_rst_n, 1'b1, 32'(r_max) <= ROW_SLOTS)
    `ASSERT_IMPLY(a_shift_pos, i_clk, i_rst_n, r_state == S_SHIFT, r_pos != '0)
    `ASSERT_IMPLY(a_commit_row_ok, i_clk, i_rst_n, commit, r_row_ok && row_has_room)

endmodule
